FILE: design/kbt_pkg.sv
// Package for the keyed budget table: state encoding, status codes and the
// command and status bundles between the controller and the datapath.
// No dependencies.
`default_nettype none

package kbt_pkg;

    localparam int unsigned KeyW    = 32;
    localparam int unsigned BudgetW = 64;
    localparam int unsigned StatusW = 2;

    // Operation codes of an input beat.
    localparam logic OP_SET    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic [StatusW-1:0] ST_OK    = 2'd0;
    localparam logic [StatusW-1:0] ST_NODEV = 2'd1;
    localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    typedef struct packed {
        logic start;   // capture the input beat and restart the scan
        logic scan;    // walk the key store
        logic decide;  // apply the update and fetch the budget
        logic load;    // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic scan_done;  // the last key compare happens this cycle
        logic out_free;   // the output register can take a result
    } t_dp_status;

endpackage

`default_nettype wire

FILE: design/kbt_ctrl.sv
// Controller of the keyed budget table: one-hot state machine that steps
// an item through scan, decide and result hand-off. Uses kbt_pkg.
`default_nettype none

module kbt_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  kbt_pkg::t_dp_status i_sts,
    output kbt_pkg::t_cmd     o_cmd
);
    import kbt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.start  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.decide = (r_state == S_DECIDE);
    assign o_cmd.load   = (r_state == S_DONE) && i_sts.out_free;

endmodule

`default_nettype wire

FILE: design/kbt_dpath.sv
// Datapath of the keyed budget table: item registers, key and budget
// memories, slot valid bits, scan counter, match logic and output register.
// Uses kbt_pkg.
`default_nettype none

module kbt_dpath #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  kbt_pkg::t_cmd                 i_cmd,
    output kbt_pkg::t_dp_status           o_sts,
    input  wire                           i_op,
    input  wire  [kbt_pkg::KeyW-1:0]      i_node_id,
    input  wire  [kbt_pkg::BudgetW-1:0]   i_budget_in,
    input  wire                           i_node_known,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [kbt_pkg::StatusW-1:0]   o_status,
    output logic [kbt_pkg::BudgetW-1:0]   o_budget_out
);
    import kbt_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Captured item.
    logic               r_op;
    logic [KeyW-1:0]    r_id;
    logic [BudgetW-1:0] r_bud;
    logic               r_known;

    // Stores. A slot is free exactly when its valid bit is clear.
    logic [KeyW-1:0]    r_key_mem [ENTRIES];
    logic [BudgetW-1:0] r_bud_mem [ENTRIES];
    logic [ENTRIES-1:0] r_slot_vld;

    // Scan pipeline.
    logic [IW:0]        r_idx;
    logic [IW-1:0]      w_rd_addr;
    logic               w_issue;
    logic               r_cmp_vld;
    logic [IW-1:0]      r_cmp_idx;
    logic [KeyW-1:0]    r_key_q;
    logic               r_vld_q;

    // Scan results.
    logic               r_found;
    logic [IW-1:0]      r_hit_idx;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;

    // Decide results.
    logic [BudgetW-1:0] r_bud_q;
    logic [StatusW-1:0] r_status;
    logic               r_lookup_hit;

    logic               w_nodev;
    logic               w_bud_zero;
    logic               w_upd_write;
    logic               w_new_write;

    logic               r_o_valid;
    logic [StatusW-1:0] r_o_status;
    logic [BudgetW-1:0] r_o_budget;

    assign w_rd_addr = r_idx[IW-1:0];
    assign w_issue   = i_cmd.scan && (r_idx < (IW+1)'(ENTRIES));

    assign w_nodev     = (r_id == '0) || !r_known;
    assign w_bud_zero  = (r_bud == '0);
    assign w_upd_write = i_cmd.decide && (r_op == OP_SET) && !w_nodev && r_found
                         && !w_bud_zero;
    assign w_new_write = i_cmd.decide && (r_op == OP_SET) && !w_nodev && !r_found
                         && !w_bud_zero && r_free_found;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_op;
            r_id    <= i_node_id;
            r_bud   <= i_budget_in;
            r_known <= i_node_known;
        end
    end

    // Memory ports: one key read per scan cycle until every slot is read, one budget
    // read at decide, one write at decide.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_key_q <= r_key_mem[w_rd_addr];
            r_vld_q <= r_slot_vld[w_rd_addr];
        end
        if (w_new_write) begin
            r_key_mem[r_free_idx] <= r_id;
        end
        if (i_cmd.decide) begin
            r_bud_q <= r_bud_mem[r_hit_idx];
        end
        if (w_upd_write) begin
            r_bud_mem[r_hit_idx] <= r_bud;
        end else if (w_new_write) begin
            r_bud_mem[r_free_idx] <= r_bud;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (w_new_write) begin
            r_slot_vld[r_free_idx] <= 1'b1;
        end else if (i_cmd.decide && (r_op == OP_SET) && !w_nodev && r_found
                     && w_bud_zero) begin
            r_slot_vld[r_hit_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_cmp_idx    <= '0;
            r_found      <= 1'b0;
            r_hit_idx    <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
        end else if (i_cmd.start) begin
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_hit_idx    <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
        end else begin
            r_cmp_vld <= w_issue;
            if (w_issue) begin
                r_idx     <= r_idx + 1'b1;
                r_cmp_idx <= w_rd_addr;
            end
            if (r_cmp_vld) begin
                // First used slot that holds the key; id zero never matches.
                if (!r_found && r_vld_q && (r_key_q == r_id) && (r_id != '0)) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                end
                if (!r_free_found && !r_vld_q) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_lookup_hit <= (r_op == OP_LOOKUP) && r_found;
            if (r_op == OP_LOOKUP) begin
                r_status <= ST_OK;
            end else if (w_nodev) begin
                r_status <= ST_NODEV;
            end else if (!r_found && !w_bud_zero && !r_free_found) begin
                r_status <= ST_FULL;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status <= r_status;
            r_o_budget <= r_lookup_hit ? r_bud_q : '0;
        end
    end

    assign o_sts.scan_done = r_cmp_vld && (r_cmp_idx == IW'(ENTRIES - 1));
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_budget_out = r_o_budget;

endmodule

`default_nettype wire

FILE: design/keyed_budget_table.sv
// Top level of the keyed budget table: joins the controller and the datapath.
// Depends on kbt_pkg, kbt_ctrl and kbt_dpath.
//
//   Channel | Handshake                  | Beat fields
//   --------+----------------------------+--------------------------------------------
//   in      | i_in_valid / o_in_ready    | i_op, i_node_id, i_budget_in, i_node_known
//   out     | o_out_valid / i_out_ready  | o_status, o_budget_out
//
// A beat is taken only in idle. A key scan (one slot read per cycle, then the last
// compare), a decide step and a load step put its result in the output register;
// the next beat is taken only once the controller is back in idle after the load.
// Reset is synchronous and active low and clears the slot valid bits at once.
// A waiting result does not hold off the next scan; only the load step stalls on it.
`default_nettype none

module keyed_budget_table #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire                           i_op,
    input  wire  [kbt_pkg::KeyW-1:0]      i_node_id,
    input  wire  [kbt_pkg::BudgetW-1:0]   i_budget_in,
    input  wire                           i_node_known,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [kbt_pkg::StatusW-1:0]   o_status,
    output logic [kbt_pkg::BudgetW-1:0]   o_budget_out
);
    import kbt_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    t_cmd       w_cmd;
    t_dp_status w_sts;

    kbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the table itself: the key and budget memories are
    // sized by ENTRIES, and a set of valid flags marks which slots are in use.
    kbt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (i_op),
        .i_node_id    (i_node_id),
        .i_budget_in  (i_budget_in),
        .i_node_known (i_node_known),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_budget_out (o_budget_out)
    );

endmodule

`default_nettype wire

FILE: design/kbt_chk.sv
// Port-level checker for the keyed budget table, bound to the top level.
// Uses kbt_pkg.
`default_nettype none

module kbt_chk (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         o_in_ready,
    input wire                         o_out_valid,
    input wire                         i_out_ready,
    input wire [kbt_pkg::StatusW-1:0]  o_status,
    input wire [kbt_pkg::BudgetW-1:0]  o_budget_out
);
    import kbt_pkg::*;

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // A stalled result keeps its budget.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_budget_out))
        else $error("stalled result budget changed");

    // The table handles one beat at a time: after an accept it is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a scan is running");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_NODEV
                         || o_status == ST_FULL))
        else $error("undefined status code");

    // A failed set never reports a budget.
    a_err_no_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_budget_out == '0))
        else $error("error result carries a budget");

endmodule

bind keyed_budget_table kbt_chk u_kbt_chk (.*);

`default_nettype wire
